// ----- hdl/ple_pkg.sv -----
`default_nettype none
package ple_pkg;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_DUMP    = 3'd2;
    localparam logic [2:0] OP_MOVE    = 3'd3;
    localparam logic [2:0] OP_REVERSE = 3'd4;
    localparam logic [2:0] OP_ROT_L   = 3'd5;
    localparam logic [2:0] OP_ROT_R   = 3'd6;
    localparam logic [2:0] OP_UNUSED  = 3'd7;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [5:0]         pos_a;
        logic [4:0]         pos_b;
        logic [30:0]        amount;
    } ple_in_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last;
        logic               empty_res;
    } ple_out_t;

endpackage
`default_nettype wire

// ----- hdl/ple_mod.sv -----
`default_nettype none
// Restoring remainder unit: one quotient bit per cycle, rem = num % den.
module ple_mod #(
    parameter int NW = 31,
    parameter int DW = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [DW-1:0]      rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;

    always_comb
    begin
        trial = {rem_reg[DW-1:0], num_reg[NW-1]};
        if (trial >= {1'b0, den_reg})
            trial = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= trial;
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign rem  = trial[DW-1:0];
endmodule
`default_nettype wire

// ----- hdl/positional_list_engine_core.sv -----
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit entries held in a one-read,
// one-write register-file memory (one read, one write per cycle,
// registered read). One item is taken at a time; ready is low while it is
// worked on. A small sequencer drives a single copy step (read one entry,
// write it in the next cycle) with which insert/remove/move shift entries;
// reverse swaps pairs, and rotate first runs a bit-serial remainder unit and
// then, unless the offset is zero, copies the list through a scratch memory
// and back. Dump delivers one item per entry, each waiting on out ready
// through the output register, or one empty-flagged item for an empty list.
// Unused op 7, out-of-range positions and a full list finish with no result.
module positional_list_engine_core #(
    parameter int CAPACITY = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ple_pkg::ple_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ple_pkg::ple_out_t     out_data
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SHUP  = 4'd2;  // open gap: entries[i]=entries[i-1]
    localparam logic [3:0] S_SHDN  = 4'd3;  // close gap: entries[i]=entries[i+1]
    localparam logic [3:0] S_PUT   = 4'd4;  // write held value at dst
    localparam logic [3:0] S_DUMP  = 4'd5;
    localparam logic [3:0] S_REV   = 4'd6;
    localparam logic [3:0] S_MOD   = 4'd7;
    localparam logic [3:0] S_ROT1  = 4'd8;  // copy rotated into scratch
    localparam logic [3:0] S_ROT2  = 4'd9;  // copy scratch back
    localparam logic [3:0] S_MGET  = 4'd10; // read move source

    logic [3:0]   state_reg;
    logic [CW-1:0] count_reg;
    ple_in_t      item_reg;
    logic [CW-1:0] i_reg;     // walk index
    logic [CW-1:0] j_reg;     // stop index / reverse upper index / rotate offset
    logic [1:0]   ph_reg;     // step phase
    logic signed [31:0] hold_reg;
    logic [AW-1:0] dst_reg;
    logic         mv_reg;     // move: open gap after close
    logic         out_valid_reg;
    ple_out_t     out_reg;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] scr [CAPACITY];
    logic signed [31:0] rd_reg, srd_reg;

    // memory port controls
    logic          re, we, sre, swe;
    logic [AW-1:0] ra, wa, sra, swa;
    logic signed [31:0] wd, swd;

    always_ff @(posedge clk)
    begin
        if (re)  rd_reg <= mem[ra];
        if (we)  mem[wa] <= wd;
        if (sre) srd_reg <= scr[sra];
        if (swe) scr[swa] <= swd;
    end

    // remainder unit for rotations
    logic          mod_start, mod_done;
    logic [CW-1:0] mod_rem;
    ple_mod #(.NW(31), .DW(CW)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start),
        .num(item_reg.amount), .den(count_reg),
        .done(mod_done), .rem(mod_rem)
    );

    wire out_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // output register takes a new item this cycle
    logic out_load;
    always_comb
    begin
        out_load = out_free &&
                   ((state_reg == S_DEC && item_reg.op == OP_DUMP && count_reg == '0) ||
                    (state_reg == S_DUMP && ph_reg == 2'd1));
    end

    // rotated source index (i + k) mod count, both below count
    logic [CW:0]   rsum;
    logic [CW-1:0] rsrc;
    always_comb
    begin
        rsum = {1'b0, i_reg} + {1'b0, j_reg};
        rsrc = (rsum >= {1'b0, count_reg}) ? CW'(rsum - {1'b0, count_reg})
                                           : rsum[CW-1:0];
    end

    always_comb
    begin
        re = 1'b0; we = 1'b0; sre = 1'b0; swe = 1'b0;
        ra = i_reg[AW-1:0]; wa = i_reg[AW-1:0];
        sra = i_reg[AW-1:0]; swa = i_reg[AW-1:0];
        wd = rd_reg; swd = rd_reg;
        mod_start = 1'b0;
        case (state_reg)
            S_SHUP:
            begin
                re = (ph_reg == 2'd0); ra = AW'(i_reg - 1'b1);
                we = (ph_reg == 2'd1);
            end
            S_SHDN:
            begin
                re = (ph_reg == 2'd0); ra = AW'(i_reg + 1'b1);
                we = (ph_reg == 2'd1);
            end
            S_MGET:  re = 1'b1;
            S_PUT:
            begin
                we = 1'b1; wa = dst_reg; wd = hold_reg;
            end
            S_DUMP:  re = (ph_reg == 2'd0);
            S_REV:
            begin
                re = (ph_reg == 2'd0) || (ph_reg == 2'd1);
                ra = (ph_reg == 2'd0) ? i_reg[AW-1:0] : j_reg[AW-1:0];
                we = (ph_reg == 2'd2) || (ph_reg == 2'd3);
                wa = (ph_reg == 2'd2) ? i_reg[AW-1:0] : j_reg[AW-1:0];
                wd = (ph_reg == 2'd2) ? rd_reg : hold_reg;
            end
            S_DEC:
                mod_start = (item_reg.op == OP_ROT_L || item_reg.op == OP_ROT_R)
                            && count_reg != '0;
            S_ROT1:
            begin
                re = (ph_reg == 2'd0); ra = rsrc[AW-1:0];
                swe = (ph_reg == 2'd1);
            end
            S_ROT2:
            begin
                sre = (ph_reg == 2'd0);
                we = (ph_reg == 2'd1); wd = srd_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            ph_reg        <= '0;
            mv_reg        <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_DEC;
                    end
                S_DEC:
                begin
                    ph_reg <= '0;
                    case (item_reg.op)
                        OP_INSERT:
                            if (count_reg < CW'(CAPACITY) &&
                                item_reg.pos_a <= 6'(count_reg))
                            begin
                                i_reg <= count_reg;
                                j_reg <= CW'(item_reg.pos_a);
                                dst_reg <= AW'(item_reg.pos_a);
                                hold_reg <= item_reg.value;
                                state_reg <= S_SHUP;
                            end
                            else
                                state_reg <= S_IDLE;
                        OP_REMOVE:
                            if (item_reg.pos_a < 6'(count_reg))
                            begin
                                i_reg <= CW'(item_reg.pos_a);
                                state_reg <= S_SHDN;
                            end
                            else
                                state_reg <= S_IDLE;
                        OP_MOVE:
                            if (item_reg.pos_a < 6'(count_reg) &&
                                6'(item_reg.pos_b) < 6'(count_reg) &&
                                item_reg.pos_a != 6'(item_reg.pos_b))
                            begin
                                i_reg <= CW'(item_reg.pos_a);
                                mv_reg <= 1'b1;
                                state_reg <= S_MGET;
                            end
                            else
                                state_reg <= S_IDLE;
                        OP_DUMP:
                            if (count_reg == '0)
                            begin
                                if (out_free)
                                begin
                                    out_reg.value_res <= -32'sd1;
                                    out_reg.last      <= 1'b1;
                                    out_reg.empty_res <= 1'b1;
                                    state_reg         <= S_IDLE;
                                end
                                else
                                    state_reg <= S_DEC;
                            end
                            else
                            begin
                                i_reg <= '0;
                                state_reg <= S_DUMP;
                            end
                        OP_REVERSE:
                            if (count_reg > CW'(1))
                            begin
                                i_reg <= '0;
                                j_reg <= count_reg - 1'b1;
                                state_reg <= S_REV;
                            end
                            else
                                state_reg <= S_IDLE;
                        OP_ROT_L, OP_ROT_R:
                            if (count_reg != '0)
                                state_reg <= S_MOD;
                            else
                                state_reg <= S_IDLE;
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_MGET:
                begin
                    state_reg <= S_SHDN;
                    ph_reg <= '0;
                end
                S_SHUP:
                    if (i_reg == j_reg)
                        state_reg <= S_PUT;
                    else if (ph_reg == 2'd0)
                        ph_reg <= 2'd1;
                    else
                    begin
                        ph_reg <= 2'd0;
                        i_reg <= i_reg - 1'b1;
                    end
                S_SHDN:
                begin
                    if (mv_reg && ph_reg == 2'd0 && i_reg == CW'(item_reg.pos_a))
                        hold_reg <= rd_reg;
                    if (i_reg + 1'b1 >= count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        if (mv_reg)
                        begin
                            i_reg <= count_reg - 1'b1;
                            j_reg <= CW'(item_reg.pos_b);
                            dst_reg <= AW'(item_reg.pos_b);
                            ph_reg <= '0;
                            mv_reg <= 1'b0;
                            state_reg <= S_SHUP;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                    else if (ph_reg == 2'd0)
                        ph_reg <= 2'd1;
                    else
                    begin
                        ph_reg <= 2'd0;
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DUMP:
                    if (ph_reg == 2'd0)
                        ph_reg <= 2'd1;
                    else if (out_free)
                    begin
                        out_reg.value_res <= rd_reg;
                        out_reg.last      <= (i_reg + 1'b1 == count_reg);
                        out_reg.empty_res <= 1'b0;
                        ph_reg <= 2'd0;
                        i_reg  <= i_reg + 1'b1;
                        if (i_reg + 1'b1 == count_reg)
                            state_reg <= S_IDLE;
                    end
                S_REV:
                begin
                    if (ph_reg == 2'd1)
                        hold_reg <= rd_reg;
                    ph_reg <= ph_reg + 1'b1;
                    if (ph_reg == 2'd3)
                    begin
                        i_reg <= i_reg + 1'b1;
                        j_reg <= j_reg - 1'b1;
                        if (i_reg + CW'(2) >= j_reg)
                            state_reg <= S_IDLE;
                    end
                end
                S_MOD:
                    if (mod_done)
                    begin
                        if (item_reg.op == OP_ROT_L)
                            j_reg <= mod_rem;
                        else
                            j_reg <= (mod_rem == '0) ? '0 : count_reg - mod_rem;
                        i_reg <= '0;
                        ph_reg <= '0;
                        if (mod_rem == '0)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_ROT1;
                    end
                S_ROT1:
                    if (ph_reg == 2'd0)
                        ph_reg <= 2'd1;
                    else
                    begin
                        ph_reg <= 2'd0;
                        if (i_reg + 1'b1 == count_reg)
                        begin
                            i_reg <= '0;
                            state_reg <= S_ROT2;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                S_ROT2:
                    if (ph_reg == 2'd0)
                        ph_reg <= 2'd1;
                    else
                    begin
                        ph_reg <= 2'd0;
                        i_reg <= i_reg + 1'b1;
                        if (i_reg + 1'b1 == count_reg)
                            state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // count never exceeds capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count overflow");
    // an empty-flagged item always closes a dump
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.empty_res |-> out_reg.last)
        else $error("empty without last");
    // no new item while a previous one is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted while busy");

endmodule
`default_nettype wire
